FILE: src/ssc_pkg.sv
// ----------------------------------------------------------------------------
// ssc_pkg
// shared types and constants of the slot phase sync controller
// ----------------------------------------------------------------------------
package ssc_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] CFG_MIN_SCORE     = 3'd0;
  localparam logic [2:0] CFG_AIM_OFFSET    = 3'd1;
  localparam logic [2:0] CFG_SAMPLES_PER_SYM = 3'd2;
  localparam logic [2:0] CFG_ACQ_STEP      = 3'd3;
  localparam logic [2:0] CFG_FINE_STEP     = 3'd4;
  localparam logic [2:0] CFG_NOMINAL_GAP   = 3'd5;
  localparam logic [2:0] CFG_SLOT_LEN      = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // loop state codes as reported on lock_state
  localparam logic [1:0] LS_ACQUIRE = 2'd0;
  localparam logic [1:0] LS_FINE    = 2'd1;
  localparam logic [1:0] LS_TRACK   = 2'd2;

  // gap reduction: magnitude bits of base gap plus correction
  localparam int DIV_BITS  = 21;
  localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the input beat
    logic prep;   // products for a report, or divider set-up for a gap request
    logic upd;    // loop state update for a report
    logic step;   // one restoring step of the slot reduction
    logic fix;    // final gap adjustment
    logic push;   // move the result into the output register
  } ssc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_gap;   // captured beat is a gap request
    logic div_last; // current step is the last of the reduction
  } ssc_stat_t;

endpackage

FILE: src/ssc_datapath.sv
// ----------------------------------------------------------------------------
// ssc_datapath
// configuration, loop state, products, slot reduction and output register
// ----------------------------------------------------------------------------
module ssc_datapath #(
  parameter int SWEEP_REPORTS   = 2,
  parameter int DITHER_COUNT    = 8,
  parameter int LATENCY_REPORTS = 1,
  parameter int WEAK_LIMIT      = 4,
  parameter int LOST_LIMIT      = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               mode,
  input  logic signed [15:0]                 score,
  input  logic signed [7:0]                  offset,
  input  logic                               confirmed,
  input  ssc_pkg::ssc_cmd_t                  cmd,
  output ssc_pkg::ssc_stat_t                 stat,
  output logic signed [20:0]                 phase_delta,
  output logic [18:0]                        gap,
  output logic [1:0]                         lock_state
);
  import ssc_pkg::*;

  localparam logic [6:0] DCNT    = 7'(DITHER_COUNT);
  localparam logic [7:0] LAT     = 8'(LATENCY_REPORTS);
  localparam logic [7:0] WLIM    = 8'(WEAK_LIMIT);
  localparam logic [7:0] LLIM    = 8'(LOST_LIMIT);
  localparam logic [7:0] SWP     = 8'(SWEEP_REPORTS);

  // configuration
  logic [14:0]        min_score;
  logic signed [7:0]  aim_offset;
  logic [12:0]        samples_per_symbol;
  logic [17:0]        acq_step;
  logic [11:0]        fine_step;
  logic [17:0]        nominal_gap;
  logic [17:0]        slot_len;

  // captured beat
  logic               mode_q;
  logic signed [15:0] score_q;
  logic signed [7:0]  offset_q;
  logic               conf_q;

  // loop state
  logic [1:0]         loop_state;
  logic [7:0]         quiet_count;
  logic [7:0]         weak_count;
  logic [7:0]         settle_count;
  logic [6:0]         dither_position;
  logic [6:0]         best_dither;
  logic signed [15:0] best_dither_score;
  logic signed [15:0] locked_score;
  logic signed [20:0] pending_correction;

  // products
  logic signed [22:0] off_prod;
  logic [18:0]        dith_prod;

  // slot reduction
  logic [DIV_BITS-1:0]  dvd;
  logic [18:0]          rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 neg;

  // result waiting for the output register
  logic signed [20:0] res_delta;
  logic [18:0]        res_gap;
  logic [1:0]         res_lock;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_score          <= 15'd10;
      aim_offset         <= 8'sd0;
      samples_per_symbol <= 13'd1920;
      acq_step           <= 18'd45000;
      fine_step          <= 12'd240;
      nominal_gap        <= 18'd28800;
      slot_len           <= 18'd180000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MIN_SCORE:       min_score          <= cfg_data[14:0];
        CFG_AIM_OFFSET:      aim_offset         <= cfg_data[7:0];
        CFG_SAMPLES_PER_SYM: samples_per_symbol <= cfg_data[12:0];
        CFG_ACQ_STEP:        acq_step           <= cfg_data[17:0];
        CFG_FINE_STEP:       fine_step          <= cfg_data[11:0];
        CFG_NOMINAL_GAP:     nominal_gap        <= cfg_data[17:0];
        CFG_SLOT_LEN:        slot_len           <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q   <= mode;
      score_q  <= score;
      offset_q <= offset;
      conf_q   <= confirmed;
    end
  end

  assign stat.is_gap   = mode_q;
  assign stat.div_last = (div_cnt == DIV_CNT_W'(1));

  // products for the report, best dither as it stands after this report
  logic signed [8:0]  off_diff;
  logic [6:0]         bd_cand;
  always_comb begin
    off_diff = $signed({offset_q[7], offset_q}) - $signed({aim_offset[7], aim_offset});
    bd_cand  = (dither_position != 7'd0 && score_q > best_dither_score)
             ? dither_position - 7'd1 : best_dither;
  end

  // divider set-up
  logic signed [21:0] gsum;
  logic [21:0]        gmag;
  logic [17:0]        slot_eff;
  always_comb begin
    gsum     = $signed({4'd0, nominal_gap}) + $signed({pending_correction[20], pending_correction});
    gmag     = gsum[21] ? 22'(-gsum) : gsum;
    slot_eff = (slot_len == 18'd0) ? 18'd1 : slot_len;
  end

  // one restoring step
  logic [18:0] rem_sh;
  logic [18:0] rem_step;
  always_comb begin
    rem_sh   = {rem[17:0], dvd[DIV_BITS-1]};
    rem_step = (rem_sh >= {1'b0, slot_eff}) ? rem_sh - {1'b0, slot_eff} : rem_sh;
  end

  // final gap adjustment
  logic [17:0] gmod;
  logic [18:0] gfin;
  always_comb begin
    gmod = (neg && rem != 19'd0) ? slot_eff - rem[17:0] : rem[17:0];
    gfin = (gmod < nominal_gap) ? {1'b0, gmod} + {1'b0, slot_eff} : {1'b0, gmod};
  end

  // report update
  logic               sig_present;
  logic signed [15:0] min16;
  logic signed [18:0] score8;
  logic signed [18:0] locked5;
  logic signed [20:0] off_sat;
  logic signed [20:0] delta;
  logic [1:0]         ls_n;
  logic [7:0]         q_n, w_n, s_n;
  logic [6:0]         dp_n, bd_n;
  logic signed [15:0] bds_n, lk_n;

  always_comb begin
    min16       = $signed({1'b0, min_score});
    sig_present = score_q >= min16;
    score8      = $signed({score_q, 3'b000});
    locked5     = $signed({locked_score[15], locked_score, 2'b00})
                + $signed({{3{locked_score[15]}}, locked_score});
    if (off_prod > 23'sd1048575) begin
      off_sat = 21'sh0FFFFF;
    end else if (off_prod < -23'sd1048576) begin
      off_sat = 21'sh100000;
    end else begin
      off_sat = off_prod[20:0];
    end

    ls_n  = loop_state;
    q_n   = quiet_count;
    w_n   = weak_count;
    s_n   = settle_count;
    dp_n  = dither_position;
    bd_n  = best_dither;
    bds_n = best_dither_score;
    lk_n  = locked_score;
    delta = 21'sd0;

    if (loop_state == LS_FINE) begin
      if (dither_position != 7'd0 && score_q > best_dither_score) begin
        bds_n = score_q;
        bd_n  = dither_position - 7'd1;
      end
      if (dither_position < DCNT) begin
        delta = $signed({9'd0, fine_step});
        dp_n  = dither_position + 7'd1;
      end else if (bds_n >= min16) begin
        delta = $signed({2'b00, dith_prod});
        lk_n  = bds_n;
        w_n   = 8'd0;
        q_n   = 8'd0;
        s_n   = LAT;
        ls_n  = LS_TRACK;
      end else begin
        q_n  = 8'd0;
        ls_n = LS_ACQUIRE;
      end
    end else if (loop_state == LS_TRACK) begin
      if (settle_count != 8'd0) begin
        s_n = settle_count - 8'd1;
      end else if (sig_present) begin
        q_n   = 8'd0;
        delta = off_sat;
        if (delta != 21'sd0) begin
          s_n = LAT;
        end
        if (score8 < locked5) begin
          w_n = weak_count + 8'd1;
          if (w_n >= WLIM) begin
            w_n   = 8'd0;
            s_n   = 8'd0;
            dp_n  = 7'd0;
            bd_n  = 7'd0;
            bds_n = 16'sd0;
            ls_n  = LS_FINE;
          end
        end else begin
          w_n = 8'd0;
          if (score_q > locked_score) begin
            lk_n = score_q;
          end
        end
      end else begin
        q_n = quiet_count + 8'd1;
        if (q_n >= LLIM) begin
          q_n  = 8'd0;
          w_n  = 8'd0;
          s_n  = 8'd0;
          ls_n = LS_ACQUIRE;
        end
      end
    end else begin
      ls_n = LS_ACQUIRE;
      if (conf_q) begin
        q_n   = 8'd0;
        delta = off_sat;
        dp_n  = 7'd0;
        bd_n  = 7'd0;
        bds_n = 16'sd0;
        ls_n  = LS_FINE;
      end else begin
        q_n = quiet_count + 8'd1;
        if (q_n >= SWP) begin
          q_n   = 8'd0;
          delta = $signed({3'd0, acq_step});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_state         <= LS_ACQUIRE;
      quiet_count        <= 8'd0;
      weak_count         <= 8'd0;
      settle_count       <= 8'd0;
      dither_position    <= 7'd0;
      best_dither        <= 7'd0;
      best_dither_score  <= 16'sd0;
      locked_score       <= 16'sd0;
      pending_correction <= 21'sd0;
    end else if (cmd.upd) begin
      loop_state         <= ls_n;
      quiet_count        <= q_n;
      weak_count         <= w_n;
      settle_count       <= s_n;
      dither_position    <= dp_n;
      best_dither        <= bd_n;
      best_dither_score  <= bds_n;
      locked_score       <= lk_n;
      pending_correction <= delta;
    end else if (cmd.prep && mode_q) begin
      pending_correction <= 21'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      off_prod  <= off_diff * $signed({1'b0, samples_per_symbol});
      dith_prod <= bd_cand * fine_step;
      dvd       <= gmag[DIV_BITS-1:0];
      neg       <= gsum[21];
      rem       <= 19'd0;
    end else if (cmd.step) begin
      dvd <= {dvd[DIV_BITS-2:0], 1'b0};
      rem <= rem_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.prep) begin
      div_cnt <= DIV_CNT_W'(DIV_BITS);
    end else if (cmd.step) begin
      div_cnt <= div_cnt - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      res_delta <= delta;
      res_gap   <= 19'd0;
      res_lock  <= ls_n;
    end else if (cmd.fix) begin
      res_delta <= 21'sd0;
      res_gap   <= gfin;
      res_lock  <= loop_state;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      phase_delta <= res_delta;
      gap         <= res_gap;
      lock_state  <= res_lock;
    end
  end

`ifndef SYNTHESIS
  a_loop_state_code: assert property (@(posedge clk) disable iff (rst)
    loop_state == LS_ACQUIRE || loop_state == LS_FINE || loop_state == LS_TRACK)
    else $error("loop state holds an unused code");

  a_gap_clears_pending: assert property (@(posedge clk) disable iff (rst)
    (cmd.prep && mode_q) |=> pending_correction == 21'sd0)
    else $error("pending correction not cleared by gap request");

  a_rem_below_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.fix |-> rem < {1'b0, slot_eff})
    else $error("slot reduction remainder out of range");
`endif

endmodule

FILE: src/ssc_ctrl.sv
// ----------------------------------------------------------------------------
// ssc_ctrl
// sequencer for one beat at a time: capture, compute, hand over
// ----------------------------------------------------------------------------
module ssc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  ssc_pkg::ssc_stat_t stat,
  output ssc_pkg::ssc_cmd_t  cmd
);
  import ssc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_UPD  = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIX  = 6'b010000,
    S_PUSH = 6'b100000
  } ctrl_state_t;

  ctrl_state_t state, state_next;
  logic        out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = stat.is_gap ? S_DIV : S_UPD;
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_PUSH;
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (stat.div_last) begin
          state_next = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix    = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> state == S_PREP)
    else $error("accepted beat did not start work");

  a_push_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> (!out_valid || !out_stall))
    else $error("result pushed over an untaken beat");

  a_valid_from_push: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.push))
    else $error("output valid without a pushed result");
`endif

endmodule

FILE: src/slot_phase_sync_controller.sv
// ----------------------------------------------------------------------------
// slot_phase_sync_controller
// slot timing lock loop: acquire sweep, fine dither search and tracking,
// with a pending phase correction turned into the next slot gap
// ----------------------------------------------------------------------------
//  channel | signals                                 | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid, in_stall, mode, score,        | into block
//          | offset, confirmed                       |
//  out     | out_valid, out_stall, phase_delta,      | out of block
//          | gap, lock_state                         |
//  config  | cfg_we, cfg_index, cfg_data             | into block
//
// a slot report goes through capture, products, loop update and hand-over
//   to the output register before the next accept
// for a gap request the 21 magnitude bits of base gap plus
//   correction go through a restoring reduction by the slot length, one bit
//   a cycle, then a sign and base-gap adjustment
// a stalled output only holds the hand-over; the next beat is taken while a
//   finished result still waits
// synchronous reset restores the register defaults and the acquire state
// ----------------------------------------------------------------------------
module slot_phase_sync_controller #(
  parameter int SWEEP_REPORTS   = 2,
  parameter int DITHER_COUNT    = 8,
  parameter int LATENCY_REPORTS = 1,
  parameter int WEAK_LIMIT      = 4,
  parameter int LOST_LIMIT      = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           mode,
  input  logic signed [15:0]             score,
  input  logic signed [7:0]              offset,
  input  logic                           confirmed,
  // result beats
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [20:0]             phase_delta,
  output logic [18:0]                    gap,
  output logic [1:0]                     lock_state
);
  import ssc_pkg::*;

  // command and status between sequencer and datapath
  ssc_cmd_t  cmd;
  ssc_stat_t stat;

  // sequencer: owns both handshakes
  ssc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath: registers, loop state, products, gap reduction, output payload
  ssc_datapath #(
    .SWEEP_REPORTS   (SWEEP_REPORTS),
    .DITHER_COUNT    (DITHER_COUNT),
    .LATENCY_REPORTS (LATENCY_REPORTS),
    .WEAK_LIMIT      (WEAK_LIMIT),
    .LOST_LIMIT      (LOST_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .score       (score),
    .offset      (offset),
    .confirmed   (confirmed),
    .cmd         (cmd),
    .stat        (stat),
    .phase_delta (phase_delta),
    .gap         (gap),
    .lock_state  (lock_state)
  );

endmodule
